[hdl/sps_pkg.sv]
`timescale 1ns / 1ps
package sps_pkg;

   localparam int BUCKETS    = 256;
   localparam int WAYS       = 4;
   localparam int PORT_LIMIT = 8;
   localparam int ENTRIES    = BUCKETS * WAYS;
   localparam int PSLOTS     = ENTRIES * PORT_LIMIT;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int IDX_W  = (PORT_LIMIT > 1) ? $clog2(PORT_LIMIT) : 1;
   localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PADR_W = (PSLOTS > 1) ? $clog2(PSLOTS) : 1;
   localparam int CNT_W  = 4;
   localparam int CIDX_W = 8;

   localparam logic [CIDX_W-1:0] REG_SCAN_ENABLE  = CIDX_W'(0);
   localparam logic [CIDX_W-1:0] REG_WINDOW_TICKS = CIDX_W'(1);
   localparam logic [30:0]       WINDOW_RESET     = 31'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EREAD,
      ST_ECHK,
      ST_PREAD,
      ST_PCHK
   } state_type;

   typedef struct packed {
      logic [31:0]      src;
      logic [31:0]      dst;
      logic [31:0]      start;
      logic [CNT_W-1:0] cnt;
   } entry_type;

endpackage

[hdl/syn_port_scan_detector.sv]
`timescale 1ns / 1ps
// TCP SYN port-scan detector. One result transfer per request transfer, in order.
// A packet that is not a TCP SYN, or any packet while scan_enable is 0, is answered
// in the cycle after its transfer, and the next request can follow at once. A checked
// SYN walks its bucket one way at a time (an ST_EREAD read of the entry memory, then
// ST_ECHK) and, on a live flow inside its window and below the port limit, searches
// its port list one slot at a time (ST_PREAD from the port memory, then ST_PCHK).
// A result that waits on rsp_tready holds off the next request. After reset a clearing
// pass wipes the valid rows one bucket at a time; no request is taken meanwhile.
module syn_port_scan_detector
   import sps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [31:0] src_addr, [63:32] dst_addr, [79:64] dst_port, [111:80] now
   input  logic [111:0]      req_tdata,
   // [0] is_tcp, [1] syn_flag
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [0] verdict, [1] scan_detected, [2] untracked, [7:3] zero
   output logic [7:0]        rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [31:0]       csr_data
);

   // storage
   logic [WAYS-1:0] vmem [BUCKETS];
   entry_type       emem [ENTRIES];
   logic [15:0]     pmem [PSLOTS];

   state_type state_ff, state_in;
   logic              enable_ff;
   logic [30:0]       window_ff;
   logic [31:0]       src_ff, dst_ff, now_ff;
   logic [15:0]       port_ff;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [WAY_W-1:0]  way_ff, way_in, free_ff, free_in;
   logic              have_free_ff, have_free_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_bits_ff, rsp_bits_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;

   logic [WAYS-1:0]   vrow_rd_ff;
   entry_type         ent_rd_ff;
   logic [15:0]       port_rd_ff;

   logic [ENT_W-1:0]  ent_addr;
   logic [PADR_W-1:0] port_addr, pw_addr;
   logic [IDX_W-1:0]  pw_idx;
   logic              v_we, e_we, p_we;
   logic [WAYS-1:0]   v_wdata;
   entry_type         e_wdata;
   logic [WAY_W-1:0]  e_way;
   logic              accept;
   logic [31:0]       sum, age;
   logic              hit, in_win, last_way, free_now;
   logic [WAY_W-1:0]  free_sel;
   logic [CNT_W-1:0]  cnt_next;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_bits_ff};

   assign sum       = req_tdata[31:0] + req_tdata[63:32];
   assign ent_addr  = ENT_W'(int'(bucket_ff) * WAYS + int'(way_ff));
   assign port_addr = PADR_W'(int'(ent_addr) * PORT_LIMIT + int'(idx_ff));
   assign age       = now_ff - ent_rd_ff.start;
   assign in_win    = age <= {1'b0, window_ff};
   assign hit       = vrow_rd_ff[way_ff] && ent_rd_ff.src == src_ff
                      && ent_rd_ff.dst == dst_ff;
   assign last_way  = way_ff == WAY_W'(WAYS - 1);
   assign free_now  = have_free_ff || !vrow_rd_ff[way_ff];
   assign free_sel  = have_free_ff ? free_ff : way_ff;
   assign cnt_next  = ent_rd_ff.cnt + CNT_W'(1);
   assign pw_addr   = PADR_W'(int'(bucket_ff) * WAYS * PORT_LIMIT
                      + int'(e_way) * PORT_LIMIT + int'(pw_idx));

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         window_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_SCAN_ENABLE) enable_ff <= csr_data[0];
         else if (csr_index == REG_WINDOW_TICKS) window_ff <= csr_data[30:0];
      end
   end

   // memory ports: registered reads at the sequencer's address
   always_ff @(posedge clock) begin
      vrow_rd_ff <= vmem[bucket_ff];
      ent_rd_ff  <= emem[ent_addr];
      port_rd_ff <= pmem[port_addr];
      if (v_we) vmem[(state_ff == ST_CLEAR) ? clr_ff : bucket_ff] <= v_wdata;
      if (e_we) emem[ENT_W'(int'(bucket_ff) * WAYS + int'(e_way))] <= e_wdata;
      if (p_we) pmem[pw_addr] <= port_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and sequencer counters
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff  <= req_tdata[31:0];
         dst_ff  <= req_tdata[63:32];
         port_ff <= req_tdata[79:64];
         now_ff  <= req_tdata[111:80];
      end
      bucket_ff    <= bucket_in;
      way_ff       <= way_in;
      free_ff      <= free_in;
      have_free_ff <= have_free_in;
      idx_ff       <= idx_in;
      rsp_bits_ff  <= rsp_bits_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      bucket_in    = bucket_ff;
      way_in       = way_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bits_in  = rsp_bits_ff;
      v_we         = 1'b0;
      v_wdata      = '0;
      e_we         = 1'b0;
      e_way        = way_ff;
      e_wdata      = '{src: src_ff, dst: dst_ff, start: now_ff, cnt: CNT_W'(1)};
      p_we         = 1'b0;
      pw_idx       = '0;
      case (state_ff)
         ST_CLEAR: begin
            v_we   = 1'b1;
            clr_in = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               bucket_in    = BKT_W'(sum % BUCKETS);
               way_in       = '0;
               have_free_in = 1'b0;
               idx_in       = '0;
               if (enable_ff && req_tuser[0] && req_tuser[1]) begin
                  state_in = ST_EREAD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = 3'b000;
               end
            end
         end
         ST_EREAD: state_in = ST_ECHK;
         ST_ECHK: begin
            if (hit) begin
               if (!in_win) begin
                  // expired window: restart with this port alone
                  e_we = 1'b1;
                  p_we = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = 3'b000;
                  state_in     = ST_IDLE;
               end else if (ent_rd_ff.cnt >= CNT_W'(PORT_LIMIT)) begin
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = 3'b001;
                  state_in     = ST_IDLE;
               end else if (ent_rd_ff.cnt == '0) begin
                  e_we = 1'b1;
                  p_we = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = {2'b00, 1'b0} | {1'b0, cnt_next >= CNT_W'(PORT_LIMIT), 1'b0};
                  state_in     = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_PREAD;
               end
            end else begin
               if (!vrow_rd_ff[way_ff] && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = way_ff;
               end
               if (last_way) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (free_now) begin
                     // claim the lowest free way
                     e_way   = free_sel;
                     e_we    = 1'b1;
                     p_we    = 1'b1;
                     v_we    = 1'b1;
                     v_wdata = vrow_rd_ff | (WAYS'(1) << free_sel);
                     rsp_bits_in = 3'b000;
                  end else begin
                     rsp_bits_in = 3'b100;
                  end
               end else begin
                  way_in   = way_ff + WAY_W'(1);
                  state_in = ST_EREAD;
               end
            end
         end
         ST_PREAD: state_in = ST_PCHK;
         ST_PCHK: begin
            if (port_rd_ff == port_ff) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = 3'b000;
               state_in     = ST_IDLE;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == ent_rd_ff.cnt) begin
               // new port: append at the count
               pw_idx        = IDX_W'(ent_rd_ff.cnt);
               p_we          = 1'b1;
               e_we          = 1'b1;
               e_wdata       = ent_rd_ff;
               e_wdata.cnt   = cnt_next;
               rsp_valid_in  = 1'b1;
               rsp_bits_in   = {1'b0, cnt_next >= CNT_W'(PORT_LIMIT), 1'b0};
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_PREAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a checked SYN enters the way walk the cycle after its transfer
   a_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && enable_ff && req_tuser[0] && req_tuser[1]) |=> state_ff == ST_EREAD)
      else $error("checked SYN did not start the way walk");
   // the port search never runs past the stored count
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PCHK) |-> CNT_W'(idx_ff) < ent_rd_ff.cnt)
      else $error("port search past count");
   // no request is taken during the clearing pass
   a_clr: assert property (@(posedge clock)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken while clearing");
endmodule
